FILE: hw/rtl/wfsd_pkg.sv
// Shared types, constants, microcode program and helper functions for the wall-follow step.
`timescale 1ns / 1ps
package wfsd_pkg;

  localparam int DEF_BODY_LEN_MM      = 310;
  localparam int DEF_BODY_WID_MM      = 140;
  localparam int DEF_ANGLE_ITERATIONS = 16;

  localparam int CORDIC_MAX = 24;
  localparam int IW         = 5;   // iteration index width
  localparam int CW         = 34;  // CORDIC x/y width
  localparam int ZW         = 25;  // CORDIC angle width
  localparam int PW         = 4;   // program counter width

  localparam logic signed [31:0] PI_Q16 = 32'sd205887;
  localparam logic [12:0] THRESHOLD_RESET = 13'd150;

  typedef logic [PW-1:0] pc_t;

  localparam pc_t PC_CORDIC = 4'd1;
  localparam pc_t PC_UNUSED = 4'd9;
  localparam pc_t PC_LAST   = 4'd9;

  typedef enum logic [1:0] {
    SIDE_LEFT   = 2'd0,
    SIDE_RIGHT  = 2'd1,
    SIDE_REAR   = 2'd2,
    SIDE_UNUSED = 2'd3
  } side_t;

  typedef enum logic [2:0] {
    REG_THRESHOLD = 3'd0,
    REG_LAT_KP    = 3'd1,
    REG_LAT_KV    = 3'd2,
    REG_LON_KP    = 3'd3,
    REG_LON_KV    = 3'd4,
    REG_YAW_KA    = 3'd5,
    REG_YAW_KW    = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    COND_NONE   = 2'd0,
    COND_LOOP   = 2'd1,
    COND_UNUSED = 2'd2
  } cond_t;

  typedef enum logic [2:0] {
    MUL_NONE   = 3'd0,
    MUL_KP_OFF = 3'd1,
    MUL_KV_V   = 3'd2,
    MUL_YAW_PI = 3'd3,
    MUL_KW_W   = 3'd4,
    MUL_KA_YR  = 3'd5
  } mul_t;

  typedef enum logic [2:0] {
    ACC_HOLD   = 3'd0,
    ACC_LOAD_V = 3'd1,
    ACC_LOAD_W = 3'd2,
    ACC_SUB_P  = 3'd3,
    ACC_SUB_PR = 3'd4
  } acc_t;

  typedef enum logic [1:0] {
    WB_NONE = 2'd0,
    WB_V    = 2'd1,
    WB_W    = 2'd2
  } wb_t;

  typedef struct packed {
    logic  init;
    logic  cstep;
    logic  yaw_ld;
    logic  yr_ld;
    mul_t  mul;
    acc_t  acc;
    wb_t   wb;
    logic  done;
    cond_t cond;
    pc_t   target;
  } ctl_t;

  typedef struct packed {
    logic iter_last;
    logic unused;
  } flags_t;

  typedef struct packed {
    logic [12:0]        threshold_mm;
    logic signed [31:0] lat_kp;
    logic signed [31:0] lat_kv;
    logic signed [31:0] lon_kp;
    logic signed [31:0] lon_kv;
    logic signed [31:0] yaw_ka;
    logic signed [31:0] yaw_kw;
  } cfg_t;

  typedef struct packed {
    logic signed [13:0] offset_mm;
    logic signed [15:0] yaw_angle;
    logic signed [31:0] axis_velocity;
    logic signed [31:0] yaw_rate;
  } res_t;

  // microcode ROM
  function automatic ctl_t ucode(input pc_t pc);
    ctl_t c;
    c = '0;
    unique case (pc)
      4'd0: begin
        c.init   = 1'b1;
        c.cond   = COND_UNUSED;
        c.target = PC_UNUSED;
      end
      4'd1: begin
        c.cstep  = 1'b1;
        c.cond   = COND_LOOP;
        c.target = PC_CORDIC;
      end
      4'd2: begin
        c.yaw_ld = 1'b1;
        c.mul    = MUL_KP_OFF;
        c.acc    = ACC_LOAD_V;
      end
      4'd3: begin
        c.mul = MUL_KV_V;
        c.acc = ACC_SUB_P;
      end
      4'd4: begin
        c.mul = MUL_YAW_PI;
        c.acc = ACC_SUB_PR;
      end
      4'd5: begin
        c.wb    = WB_V;
        c.acc   = ACC_LOAD_W;
        c.yr_ld = 1'b1;
        c.mul   = MUL_KW_W;
      end
      4'd6: begin
        c.mul = MUL_KA_YR;
        c.acc = ACC_SUB_PR;
      end
      4'd7: begin
        c.acc = ACC_SUB_PR;
      end
      4'd8: begin
        c.wb   = WB_W;
        c.done = 1'b1;
      end
      default: begin
        c.done = 1'b1;
      end
    endcase
    return c;
  endfunction

  // arctangent of 2^-i in units of pi/2^23
  function automatic logic [22:0] atan_val(input logic [IW-1:0] i);
    logic [22:0] r;
    unique case (i)
      5'd0:    r = 23'd2097152;
      5'd1:    r = 23'd1238021;
      5'd2:    r = 23'd654136;
      5'd3:    r = 23'd332050;
      5'd4:    r = 23'd166669;
      5'd5:    r = 23'd83416;
      5'd6:    r = 23'd41718;
      5'd7:    r = 23'd20860;
      5'd8:    r = 23'd10430;
      5'd9:    r = 23'd5215;
      5'd10:   r = 23'd2608;
      5'd11:   r = 23'd1304;
      5'd12:   r = 23'd652;
      5'd13:   r = 23'd326;
      5'd14:   r = 23'd163;
      5'd15:   r = 23'd81;
      5'd16:   r = 23'd41;
      5'd17:   r = 23'd20;
      5'd18:   r = 23'd10;
      5'd19:   r = 23'd5;
      5'd20:   r = 23'd3;
      5'd21:   r = 23'd1;
      5'd22:   r = 23'd1;
      default: r = 23'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/wfsd_seq.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
`timescale 1ns / 1ps
module wfsd_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            out_free,
  input  wfsd_pkg::flags_t flags,
  output wfsd_pkg::ctl_t  ctl,
  output logic            run,
  output logic            busy
);
  import wfsd_pkg::*;

  pc_t  pc_r, pc_nxt;
  logic busy_r, busy_nxt;
  logic taken;

  assign ctl  = ucode(pc_r);
  assign busy = busy_r;
  assign run  = busy_r && (!ctl.done || out_free);

  always_comb begin
    unique case (ctl.cond)
      COND_LOOP:   taken = !flags.iter_last;
      COND_UNUSED: taken = flags.unused;
      default:     taken = 1'b0;
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        pc_nxt   = '0;
      end
    end else if (run) begin
      if (ctl.done) begin
        busy_nxt = 1'b0;
      end else if (taken) begin
        pc_nxt = ctl.target;
      end else begin
        pc_nxt = pc_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= '0;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
    end
  end

  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> pc_r <= PC_LAST)
    else $error("program counter beyond program");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy_r) |=> (busy_r && pc_r == '0))
    else $error("start did not enter program at step zero");

endmodule

FILE: hw/rtl/wfsd_dp.sv
// Datapath: offset, shared CORDIC stage, one multiplier, accumulator and velocity state.
`timescale 1ns / 1ps
module wfsd_dp #(
  parameter int BODY_LEN_MM      = wfsd_pkg::DEF_BODY_LEN_MM,
  parameter int BODY_WID_MM      = wfsd_pkg::DEF_BODY_WID_MM,
  parameter int ANGLE_ITERATIONS = wfsd_pkg::DEF_ANGLE_ITERATIONS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  logic [1:0]       cmd,
  input  logic [12:0]      dist_first,
  input  logic [12:0]      dist_second,
  input  wfsd_pkg::cfg_t   cfg,
  input  wfsd_pkg::ctl_t   ctl,
  input  logic             run,
  output wfsd_pkg::flags_t flags,
  output wfsd_pkg::res_t   res
);
  import wfsd_pkg::*;

  localparam int ITER_N = (ANGLE_ITERATIONS > CORDIC_MAX) ? CORDIC_MAX : ANGLE_ITERATIONS;
  localparam int LEN_X  = BODY_LEN_MM * 65536;
  localparam int WID_X  = BODY_WID_MM * 65536;
  localparam logic [IW-1:0] I_LAST = IW'(ITER_N - 1);

  side_t                 cmd_r, cmd_nxt;
  logic [12:0]           a_r, a_nxt, b_r, b_nxt;
  logic signed [13:0]    off_r, off_nxt;
  logic signed [CW-1:0]  x_r, x_nxt, y_r, y_nxt;
  logic signed [ZW-1:0]  z_r, z_nxt;
  logic [IW-1:0]         i_r, i_nxt;
  logic signed [15:0]    yaw_r, yaw_nxt;
  logic signed [19:0]    yr_r, yr_nxt;
  logic signed [63:0]    prod_r, prod_nxt, acc_r, acc_nxt;
  logic signed [31:0]    lat_v_r, lat_v_nxt, lon_v_r, lon_v_nxt, ang_r, ang_nxt;

  logic                  rear, unused;
  logic [13:0]           sum;
  logic signed [13:0]    off_raw, diff;
  logic signed [CW-1:0]  xs, ys;
  logic signed [ZW-1:0]  at;
  logic signed [25:0]    zr;
  logic signed [63:0]    rnd16, rnd15;
  logic signed [31:0]    ma, mb, v_cur, kp, kv, vsat;

  assign rear   = (cmd_r == SIDE_REAR);
  assign unused = (cmd_r == SIDE_UNUSED);

  assign sum     = {1'b0, a_r} + {1'b0, b_r};
  assign off_raw = $signed({1'b0, sum[13:1]}) - $signed({1'b0, cfg.threshold_mm});
  assign diff    = (cmd_r == SIDE_RIGHT) ? ($signed({1'b0, a_r}) - $signed({1'b0, b_r}))
                                         : ($signed({1'b0, b_r}) - $signed({1'b0, a_r}));

  assign xs = x_r >>> i_r;
  assign ys = y_r >>> i_r;
  assign at = $signed({2'b00, atan_val(i_r)});
  assign zr = ($signed({z_r[ZW-1], z_r}) + 26'sd128) >>> 8;

  assign rnd16 = (prod_r + 64'sd32768) >>> 16;
  assign rnd15 = (prod_r + 64'sd16384) >>> 15;

  assign v_cur = rear ? lon_v_r : lat_v_r;
  assign kp    = rear ? cfg.lon_kp : cfg.lat_kp;
  assign kv    = rear ? cfg.lon_kv : cfg.lat_kv;
  assign vsat  = sat32(acc_r);

  always_comb begin
    unique case (ctl.mul)
      MUL_KP_OFF: begin ma = kp;                        mb = {{18{off_r[13]}}, off_r}; end
      MUL_KV_V:   begin ma = kv;                        mb = v_cur; end
      MUL_YAW_PI: begin ma = {{16{yaw_r[15]}}, yaw_r};  mb = PI_Q16; end
      MUL_KW_W:   begin ma = cfg.yaw_kw;                mb = ang_r; end
      MUL_KA_YR:  begin ma = cfg.yaw_ka;                mb = {{12{yr_r[19]}}, yr_r}; end
      default:    begin ma = '0;                        mb = '0; end
    endcase
  end

  always_comb begin
    cmd_nxt   = cmd_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    off_nxt   = off_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    i_nxt     = i_r;
    yaw_nxt   = yaw_r;
    yr_nxt    = yr_r;
    prod_nxt  = prod_r;
    acc_nxt   = acc_r;
    lat_v_nxt = lat_v_r;
    lon_v_nxt = lon_v_r;
    ang_nxt   = ang_r;

    if (load) begin
      cmd_nxt = side_t'(cmd);
      a_nxt   = dist_first;
      b_nxt   = dist_second;
    end

    if (run) begin
      if (ctl.init) begin
        off_nxt = (cmd_r == SIDE_LEFT) ? -off_raw : off_raw;
        x_nxt   = rear ? CW'(WID_X) : CW'(LEN_X);
        y_nxt   = {{(CW-30){diff[13]}}, diff, 16'd0};
        z_nxt   = '0;
        i_nxt   = '0;
      end
      if (ctl.cstep) begin
        if (y_r[CW-1]) begin
          x_nxt = x_r - ys;
          y_nxt = y_r + xs;
          z_nxt = z_r - at;
        end else begin
          x_nxt = x_r + ys;
          y_nxt = y_r - xs;
          z_nxt = z_r + at;
        end
        i_nxt = i_r + 1'b1;
      end
      if (ctl.yaw_ld) begin
        if (zr > 26'sd16384) begin
          yaw_nxt = 16'sd16384;
        end else if (zr < -26'sd16384) begin
          yaw_nxt = -16'sd16384;
        end else begin
          yaw_nxt = zr[15:0];
        end
      end
      if (ctl.yr_ld) begin
        yr_nxt = rnd15[19:0];
      end
      if (ctl.mul != MUL_NONE) begin
        prod_nxt = ma * mb;
      end
      unique case (ctl.acc)
        ACC_LOAD_V: acc_nxt = {{32{v_cur[31]}}, v_cur};
        ACC_LOAD_W: acc_nxt = {{32{ang_r[31]}}, ang_r};
        ACC_SUB_P:  acc_nxt = acc_r - prod_r;
        ACC_SUB_PR: acc_nxt = acc_r - rnd16;
        default:    acc_nxt = acc_r;
      endcase
      unique case (ctl.wb)
        WB_V: begin
          if (rear) begin
            lon_v_nxt = vsat;
          end else begin
            lat_v_nxt = vsat;
          end
        end
        WB_W:    ang_nxt = vsat;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_v_r <= '0;
      lon_v_r <= '0;
      ang_r   <= '0;
      i_r     <= '0;
    end else begin
      lat_v_r <= lat_v_nxt;
      lon_v_r <= lon_v_nxt;
      ang_r   <= ang_nxt;
      i_r     <= i_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    off_r  <= off_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    yaw_r  <= yaw_nxt;
    yr_r   <= yr_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  assign flags.iter_last = (i_r == I_LAST);
  assign flags.unused    = unused;

  assign res.offset_mm     = unused ? 14'sd0 : off_r;
  assign res.yaw_angle     = unused ? 16'sd0 : yaw_r;
  assign res.axis_velocity = rear ? lon_v_r : lat_v_r;
  assign res.yaw_rate      = unused ? ang_r : vsat;

  a_iter_range: assert property (@(posedge clk) disable iff (!rst_n)
    (run && ctl.cstep) |-> i_r <= I_LAST)
    else $error("CORDIC iteration index beyond count");

endmodule

FILE: hw/rtl/wall_follow_spring_damper_step.sv
// Top level: handshakes, configuration registers, result word register, sequencer and datapath.
`timescale 1ns / 1ps
// Steps from input accept to out_valid: one set-up step, the CORDIC loop (one iteration per cycle)
//   and seven multiply/accumulate and write-back steps; the last step waits until the output register is free.
// A new input word is taken only after the last one finishes; an unused side code skips to the last step.
// The next input word is taken while a result word still waits at the output.
// Reset (rst_n low, synchronous): velocities and yaw rate cleared, threshold 150, gains 0.
module wall_follow_spring_damper_step #(
  parameter int BODY_LEN_MM      = wfsd_pkg::DEF_BODY_LEN_MM,
  parameter int BODY_WID_MM      = wfsd_pkg::DEF_BODY_WID_MM,
  parameter int ANGLE_ITERATIONS = wfsd_pkg::DEF_ANGLE_ITERATIONS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_cmd,
  input  logic [12:0]        in_dist_first,
  input  logic [12:0]        in_dist_second,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [13:0] out_offset_mm,
  output logic signed [15:0] out_yaw_angle,
  output logic signed [31:0] out_axis_velocity,
  output logic signed [31:0] out_yaw_rate,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import wfsd_pkg::*;

  cfg_t   cfg_r, cfg_nxt;
  res_t   res, res_r;
  logic   out_valid_r, out_valid_nxt;
  ctl_t   ctl;
  flags_t flags;
  logic   run, busy, start, out_free;

  assign cfg_ready = 1'b1;
  assign in_ready  = !busy;
  assign start     = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_THRESHOLD: cfg_nxt.threshold_mm = cfg_data[12:0];
        REG_LAT_KP:    cfg_nxt.lat_kp       = cfg_data;
        REG_LAT_KV:    cfg_nxt.lat_kv       = cfg_data;
        REG_LON_KP:    cfg_nxt.lon_kp       = cfg_data;
        REG_LON_KV:    cfg_nxt.lon_kv       = cfg_data;
        REG_YAW_KA:    cfg_nxt.yaw_ka       = cfg_data;
        REG_YAW_KW:    cfg_nxt.yaw_kw       = cfg_data;
        default:       ;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (run && ctl.done) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '{threshold_mm: THRESHOLD_RESET, default: '0};
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (run && ctl.done) begin
      res_r <= res;
    end
  end

  wfsd_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .out_free (out_free),
    .flags    (flags),
    .ctl      (ctl),
    .run      (run),
    .busy     (busy)
  );

  wfsd_dp #(
    .BODY_LEN_MM      (BODY_LEN_MM),
    .BODY_WID_MM      (BODY_WID_MM),
    .ANGLE_ITERATIONS (ANGLE_ITERATIONS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (start),
    .cmd         (in_cmd),
    .dist_first  (in_dist_first),
    .dist_second (in_dist_second),
    .cfg         (cfg_r),
    .ctl         (ctl),
    .run         (run),
    .flags       (flags),
    .res         (res)
  );

  assign out_valid         = out_valid_r;
  assign out_offset_mm     = res_r.offset_mm;
  assign out_yaw_angle     = res_r.yaw_angle;
  assign out_axis_velocity = res_r.axis_velocity;
  assign out_yaw_rate      = res_r.yaw_rate;

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second word taken while one is in flight");

  a_done_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (run && ctl.done) |=> out_valid)
    else $error("finished word not presented");

endmodule

FILE: tb/sv/wfsd_step_checker.sv
// Checker for the wall-follow step: tracks register writes, predicts each result word, compares.
`timescale 1ns / 1ps
module wfsd_step_checker #(
  parameter int BODY_LEN   = wfsd_pkg::DEF_BODY_LEN_MM,
  parameter int BODY_WID   = wfsd_pkg::DEF_BODY_WID_MM,
  parameter int ITERATIONS = wfsd_pkg::DEF_ANGLE_ITERATIONS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         in_cmd,
  input  logic [12:0]        in_dist_first,
  input  logic [12:0]        in_dist_second,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [13:0] out_offset_mm,
  input  logic signed [15:0] out_yaw_angle,
  input  logic signed [31:0] out_axis_velocity,
  input  logic signed [31:0] out_yaw_rate,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 errors,
  output int                 pending
);

  // arctan(2^-i) in units of pi/2^23
  longint atan_step [24] = '{
    2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
    10430, 5215, 2608, 1304, 652, 326, 163, 81,
    41, 20, 10, 5, 3, 1, 1, 0
  };

  logic [12:0]        threshold;
  logic signed [31:0] lat_kp, lat_kv, lon_kp, lon_kv, yaw_ka, yaw_kw;
  logic signed [31:0] lat_vel, lon_vel, ang_rate;

  wfsd_pkg::res_t awaited [$];
  wfsd_pkg::res_t want;

  function automatic logic signed [31:0] clamp_q16(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint q16_product(input longint a, input longint b);
    return (a * b + 64'sd32768) >>> 16;
  endfunction

  // vectoring arctangent, result in pi/32768 units
  function automatic longint yaw_units(input longint rise, input longint run);
    longint x, y, z, xs, ys, r;
    int     n, i;
    x = run * 65536;
    y = rise * 65536;
    z = 0;
    n = (ITERATIONS > 24) ? 24 : ITERATIONS;
    for (i = 0; i < n; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y < 0) begin
        x = x - ys;
        y = y + xs;
        z = z - atan_step[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + atan_step[i];
      end
    end
    r = (z + 128) >>> 8;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r;
  endfunction

  function automatic wfsd_pkg::res_t advance_controller(input logic [1:0] side,
                                                        input logic [12:0] first,
                                                        input logic [12:0] second);
    wfsd_pkg::res_t     r;
    longint             a, b, off, rise, run, yaw, yaw_rad, v, kp, kv, w;
    logic signed [31:0] v_next;
    if (side == wfsd_pkg::SIDE_UNUSED) begin
      r.offset_mm     = '0;
      r.yaw_angle     = '0;
      r.axis_velocity = lat_vel;
      r.yaw_rate      = ang_rate;
      return r;
    end
    a    = longint'(first);
    b    = longint'(second);
    off  = (a + b) / 2 - longint'(threshold);
    if (side == wfsd_pkg::SIDE_LEFT) off = -off;
    rise = (side == wfsd_pkg::SIDE_RIGHT) ? a - b : b - a;
    run  = (side == wfsd_pkg::SIDE_REAR) ? BODY_WID : BODY_LEN;
    if (run < 1) run = 1;
    yaw  = yaw_units(rise, run);
    if (side == wfsd_pkg::SIDE_REAR) begin
      v  = lon_vel;
      kp = lon_kp;
      kv = lon_kv;
    end else begin
      v  = lat_vel;
      kp = lat_kp;
      kv = lat_kv;
    end
    v_next = clamp_q16(v - kp * off - q16_product(kv, v));
    if (side == wfsd_pkg::SIDE_REAR) lon_vel = v_next;
    else lat_vel = v_next;
    yaw_rad  = (yaw * longint'(wfsd_pkg::PI_Q16) + 16384) >>> 15;
    w        = ang_rate;
    ang_rate = clamp_q16(w - q16_product(yaw_ka, yaw_rad) - q16_product(yaw_kw, w));
    r.offset_mm     = off[13:0];
    r.yaw_angle     = yaw[15:0];
    r.axis_velocity = v_next;
    r.yaw_rate      = ang_rate;
    return r;
  endfunction

  task automatic compare_field(input string name, input logic signed [31:0] exp_v,
                               input logic signed [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      errors    = 0;
      threshold = wfsd_pkg::THRESHOLD_RESET;
      lat_kp    = '0;
      lat_kv    = '0;
      lon_kp    = '0;
      lon_kv    = '0;
      yaw_ka    = '0;
      yaw_kw    = '0;
      lat_vel   = '0;
      lon_vel   = '0;
      ang_rate  = '0;
      awaited.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (awaited.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          want = awaited.pop_front();
          compare_field("offset_mm", want.offset_mm, out_offset_mm);
          compare_field("yaw_angle", want.yaw_angle, out_yaw_angle);
          compare_field("axis_velocity", want.axis_velocity, out_axis_velocity);
          compare_field("yaw_rate", want.yaw_rate, out_yaw_rate);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          wfsd_pkg::REG_THRESHOLD: threshold = cfg_data[12:0];
          wfsd_pkg::REG_LAT_KP:    lat_kp    = cfg_data;
          wfsd_pkg::REG_LAT_KV:    lat_kv    = cfg_data;
          wfsd_pkg::REG_LON_KP:    lon_kp    = cfg_data;
          wfsd_pkg::REG_LON_KV:    lon_kv    = cfg_data;
          wfsd_pkg::REG_YAW_KA:    yaw_ka    = cfg_data;
          wfsd_pkg::REG_YAW_KW:    yaw_kw    = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        awaited.push_back(advance_controller(in_cmd, in_dist_first, in_dist_second));
      end
    end
    pending = awaited.size();
  end

endmodule

FILE: tb/sv/tb_wall_follow_spring_damper_step.sv
// Testbench top for the wall-follow spring-damper step: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_wall_follow_spring_damper_step;

  localparam int         CYCLE_LIMIT   = 400000;
  localparam int         DRAIN_CYCLES  = 40;
  localparam int         PHASE_WORDS   = 150;
  localparam logic [2:0] CFG_IDX_SPARE = 3'd7;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_cmd;
  logic [12:0]        in_dist_first;
  logic [12:0]        in_dist_second;
  logic               out_valid;
  logic               out_ready;
  logic signed [13:0] out_offset_mm;
  logic signed [15:0] out_yaw_angle;
  logic signed [31:0] out_axis_velocity;
  logic signed [31:0] out_yaw_rate;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;

  int fails;
  int pending;
  int send_idle_pct;
  int recv_stall_pct;
  int cur_threshold;
  int cycle_count;

  wall_follow_spring_damper_step DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_dist_first     (in_dist_first),
    .in_dist_second    (in_dist_second),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_offset_mm     (out_offset_mm),
    .out_yaw_angle     (out_yaw_angle),
    .out_axis_velocity (out_axis_velocity),
    .out_yaw_rate      (out_yaw_rate),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  wfsd_step_checker u_step_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_dist_first     (in_dist_first),
    .in_dist_second    (in_dist_second),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_offset_mm     (out_offset_mm),
    .out_yaw_angle     (out_yaw_angle),
    .out_axis_velocity (out_axis_velocity),
    .out_yaw_rate      (out_yaw_rate),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .errors            (fails),
    .pending           (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic [12:0] to_reading(input int mm);
    if (mm < 0) return 13'd0;
    if (mm > 8191) return 13'd8191;
    return mm[12:0];
  endfunction

  function automatic logic [31:0] mild_gain(input int span);
    return 32'($urandom_range(2 * span) - span);
  endfunction

  task automatic push_word(input wfsd_pkg::side_t side, input logic [12:0] first,
                           input logic [12:0] second);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid       = 1'b1;
    in_cmd         = side;
    in_dist_first  = first;
    in_dist_second = second;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic quiesce();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic load_gains(input logic [12:0] thr, input logic [31:0] lat_p,
                            input logic [31:0] lat_v, input logic [31:0] lon_p,
                            input logic [31:0] lon_v, input logic [31:0] ka,
                            input logic [31:0] kw);
    quiesce();
    write_reg(wfsd_pkg::REG_THRESHOLD, {19'd0, thr});
    write_reg(wfsd_pkg::REG_LAT_KP, lat_p);
    write_reg(wfsd_pkg::REG_LAT_KV, lat_v);
    write_reg(wfsd_pkg::REG_LON_KP, lon_p);
    write_reg(wfsd_pkg::REG_LON_KV, lon_v);
    write_reg(wfsd_pkg::REG_YAW_KA, ka);
    write_reg(wfsd_pkg::REG_YAW_KW, kw);
    cur_threshold = int'(thr);
  endtask

  task automatic random_word();
    wfsd_pkg::side_t side;
    int              pick, centre, first;
    pick = $urandom_range(99);
    if (pick < 8) side = wfsd_pkg::SIDE_UNUSED;
    else side = wfsd_pkg::side_t'($urandom_range(2));
    pick = $urandom_range(9);
    if (pick < 3) begin
      push_word(side, 13'($urandom), 13'($urandom));
    end else if (pick < 8) begin
      // near the target distance, small skew
      centre = cur_threshold + int'($urandom_range(400)) - 200;
      first  = centre + int'($urandom_range(80)) - 40;
      push_word(side, to_reading(first),
                to_reading(first + int'($urandom_range(240)) - 120));
    end else begin
      push_word(side, $urandom_range(1) ? 13'd8191 : 13'd0,
                $urandom_range(1) ? 13'd8191 : 13'd0);
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_cmd         = wfsd_pkg::SIDE_LEFT;
    in_dist_first  = '0;
    in_dist_second = '0;
    cfg_valid      = 1'b0;
    cfg_index      = wfsd_pkg::REG_THRESHOLD;
    cfg_data       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cur_threshold  = 150;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // reset configuration
    push_word(wfsd_pkg::SIDE_LEFT, 13'd150, 13'd150);
    push_word(wfsd_pkg::SIDE_RIGHT, 13'd0, 13'd8191);
    push_word(wfsd_pkg::SIDE_REAR, 13'd8191, 13'd0);
    push_word(wfsd_pkg::SIDE_UNUSED, 13'd8191, 13'd8191);

    // spare index must be ignored; extreme gains drive saturation
    quiesce();
    write_reg(CFG_IDX_SPARE, 32'hffffffff);
    load_gains(13'd0, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
               32'h7fffffff, 32'h80000000);
    push_word(wfsd_pkg::SIDE_LEFT, 13'd0, 13'd0);
    push_word(wfsd_pkg::SIDE_LEFT, 13'd8191, 13'd8191);
    push_word(wfsd_pkg::SIDE_LEFT, 13'd8191, 13'd8191);
    push_word(wfsd_pkg::SIDE_RIGHT, 13'd8191, 13'd8191);
    push_word(wfsd_pkg::SIDE_REAR, 13'd0, 13'd0);
    push_word(wfsd_pkg::SIDE_LEFT, 13'd0, 13'd8191);
    push_word(wfsd_pkg::SIDE_LEFT, 13'd8191, 13'd0);
    push_word(wfsd_pkg::SIDE_RIGHT, 13'd0, 13'd8191);
    push_word(wfsd_pkg::SIDE_RIGHT, 13'd8191, 13'd0);
    push_word(wfsd_pkg::SIDE_REAR, 13'd0, 13'd8191);
    push_word(wfsd_pkg::SIDE_REAR, 13'd8191, 13'd0);
    push_word(wfsd_pkg::SIDE_REAR, 13'd140, 13'd280);
    push_word(wfsd_pkg::SIDE_UNUSED, 13'd0, 13'd0);
    push_word(wfsd_pkg::SIDE_REAR, 13'd8191, 13'd8191);
    load_gains(13'd8191, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
               32'h80000000, 32'h7fffffff);
    push_word(wfsd_pkg::SIDE_LEFT, 13'd0, 13'd0);
    push_word(wfsd_pkg::SIDE_RIGHT, 13'd0, 13'd0);
    push_word(wfsd_pkg::SIDE_REAR, 13'd0, 13'd1);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          load_gains(13'd150, 32'sd1311, 32'sd6554, 32'sd2000, 32'sd9830,
                     32'sd65536, 32'sd13107);
        end
        1: begin
          send_idle_pct  = 73;
          recv_stall_pct = 0;
          load_gains(13'($urandom_range(600)), mild_gain(20000), mild_gain(40000),
                     mild_gain(20000), mild_gain(40000), mild_gain(200000),
                     mild_gain(40000));
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 73;
          load_gains(13'd8191, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                     32'h80000000, 32'h80000000);
        end
        default: begin
          send_idle_pct  = 38;
          recv_stall_pct = 38;
          load_gains(13'($urandom), $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom);
        end
      endcase
      repeat (PHASE_WORDS) begin
        if ($urandom_range(99) < 2) quiesce();
        random_word();
      end
    end

    in_valid       = 1'b0;
    recv_stall_pct = 0;
    quiesce();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: wall_follow_spring_damper_step.f
hw/rtl/wfsd_pkg.sv
hw/rtl/wfsd_seq.sv
hw/rtl/wfsd_dp.sv
hw/rtl/wall_follow_spring_damper_step.sv
tb/sv/wfsd_step_checker.sv
tb/sv/tb_wall_follow_spring_damper_step.sv
